[src/krd_pkg.sv]
// Package with request, response and record types and codes for the keyed record deque.
package krd_pkg;

    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int OCC_W  = 7;

    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [2:0] ACT_POP_BACK   = 3'd3;
    localparam logic [2:0] ACT_FIND       = 3'd4;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_EMPTY     = 2'd1;
    localparam logic [1:0] STS_FULL      = 2'd2;
    localparam logic [1:0] STS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [2:0]               action;
        logic signed [KEY_W-1:0]  key;
        logic [DATA_W-1:0]        payload;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [KEY_W-1:0]  key_out;
        logic [DATA_W-1:0]        payload_out;
        logic [OCC_W-1:0]         occupancy;
    } rsp_t;

    typedef struct packed {
        logic signed [KEY_W-1:0]  key;
        logic [DATA_W-1:0]        payload;
    } rec_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_SCAN
    } state_t;

endpackage

[src/krd_ram.sv]
// Single-port-write, single-port-read record memory with a registered read.
module krd_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  krd_pkg::rec_t      wdata,
    input  logic [AW-1:0]      raddr,
    output krd_pkg::rec_t      rdata
);
    import krd_pkg::*;

    rec_t mem [DEPTH];
    rec_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/keyed_record_deque.sv]
// Top level of the keyed record deque: ring-buffer control, find scan and result register.
//
//  Channel   | Ports                  | Handshake
//  ----------+------------------------+-------------------------------------------
//  request   | start, busy, req       | taken at a rising edge with start=1, busy=0
//  result    | done, rsp              | done high for one cycle, cannot be stalled
//
// Push, a refused push, a pop or find on an empty deque and an undefined action answer
// straight from idle; the result appears the cycle after the request and busy never rises.
// A pop first reads the record memory and then, in ST_POP, registers the result.
// A find reads one stored record per cycle through the single memory read port, from
// the front, and stops at the first matching record or after the back record.
// Reset clears the front pointer, the record count, the state machine and the done flag
// only; the record memory is never cleared, since only occupied entries are ever used.
module keyed_record_deque #(
    parameter int CAPACITY = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  krd_pkg::req_t  req,
    output logic           done,
    output krd_pkg::rsp_t  rsp
);
    import krd_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
    localparam logic [AW:0]   CAP_EXT  = (AW + 1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);

    // Position that lies a given number of records behind base, modulo the capacity.
    // Both operands are below the capacity, so one conditional subtract suffices.
    function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                               input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= CAP_EXT)
        begin
            sum = sum - CAP_EXT;
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
        return (a == LAST_IDX) ? '0 : a + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] a);
        return (a == '0) ? LAST_IDX : a - AW'(1);
    endfunction

    state_t         state_reg, state_next;
    logic [AW-1:0]  front_reg, front_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  scan_reg, scan_next;
    logic [AW-1:0]  addr_reg;
    req_t           req_reg, req_next;
    logic           done_reg, done_next;
    rsp_t           rsp_reg, rsp_next;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    rec_t           ram_wdata;
    logic [AW-1:0]  ram_raddr;
    rec_t           ram_rdata;

    logic           accept;
    logic           is_full;
    logic           is_empty;
    logic [CW-1:0]  count_m1;
    logic [AW-1:0]  back_pos;
    logic [AW-1:0]  last_pos;
    logic           scan_hit;
    logic           scan_last;

    // The record memory holds key and payload side by side, one record per entry.
    krd_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && (state_reg == ST_IDLE);
    assign is_full   = (count_reg == CAP_CNT);
    assign is_empty  = (count_reg == '0);
    assign count_m1  = count_reg - CW'(1);
    // Slot just past the back record; only used when the deque is not full.
    assign back_pos  = ring_pos(front_reg, count_reg[AW-1:0]);
    // Slot of the back record; only used when the deque is not empty.
    assign last_pos  = ring_pos(front_reg, count_m1[AW-1:0]);
    assign scan_hit  = (ram_rdata.key == req_reg.key);
    assign scan_last = ((scan_reg + CW'(1)) == count_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (((req.action == ACT_POP_FRONT) || (req.action == ACT_POP_BACK))
                        && !is_empty)
                    begin
                        state_next = ST_POP;
                    end
                    else if ((req.action == ACT_FIND) && !is_empty)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_POP:
            begin
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (scan_hit || scan_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory access and result.
    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        scan_next   = scan_reg;
        req_next    = req_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;
        ram_we      = 1'b0;
        ram_waddr   = back_pos;
        ram_wdata   = '{key: req.key, payload: req.payload};
        ram_raddr   = addr_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next  = req;
                    scan_next = '0;
                    rsp_next  = '{status: STS_OK, key_out: '0, payload_out: '0,
                                  occupancy: OCC_W'(count_reg)};
                    case (req.action)
                        ACT_PUSH_FRONT, ACT_PUSH_BACK:
                        begin
                            done_next = 1'b1;
                            if (is_full)
                            begin
                                rsp_next.status = STS_FULL;
                            end
                            else
                            begin
                                ram_we = 1'b1;
                                if (req.action == ACT_PUSH_FRONT)
                                begin
                                    front_next = ring_dec(front_reg);
                                    ram_waddr  = ring_dec(front_reg);
                                end
                                count_next         = count_reg + CW'(1);
                                rsp_next.occupancy = OCC_W'(count_reg + CW'(1));
                            end
                        end
                        ACT_POP_FRONT, ACT_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                done_next       = 1'b1;
                                rsp_next.status = STS_EMPTY;
                            end
                            else
                            begin
                                if (req.action == ACT_POP_FRONT)
                                begin
                                    ram_raddr  = front_reg;
                                    front_next = ring_inc(front_reg);
                                end
                                else
                                begin
                                    ram_raddr = last_pos;
                                end
                                count_next = count_m1;
                            end
                        end
                        ACT_FIND:
                        begin
                            if (is_empty)
                            begin
                                done_next       = 1'b1;
                                rsp_next.status = STS_NOT_FOUND;
                            end
                            else
                            begin
                                ram_raddr = front_reg;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                done_next = 1'b1;
                rsp_next  = '{status: STS_OK, key_out: ram_rdata.key,
                              payload_out: ram_rdata.payload,
                              occupancy: OCC_W'(count_reg)};
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    done_next = 1'b1;
                    rsp_next  = '{status: STS_OK, key_out: ram_rdata.key,
                                  payload_out: ram_rdata.payload,
                                  occupancy: OCC_W'(count_reg)};
                end
                else if (scan_last)
                begin
                    done_next = 1'b1;
                    rsp_next  = '{status: STS_NOT_FOUND, key_out: '0, payload_out: '0,
                                  occupancy: OCC_W'(count_reg)};
                end
                else
                begin
                    // Fetch the next record while this one is compared.
                    ram_raddr = ring_inc(addr_reg);
                    scan_next = scan_reg + CW'(1);
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            front_reg <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        addr_reg <= ram_raddr;
        req_reg  <= req_next;
        rsp_reg  <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // The record count never exceeds the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("record count above capacity");

    // The front pointer always names a slot inside the ring.
    a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
        front_reg <= LAST_IDX)
        else $error("front pointer outside the ring");

    // A push request always answers in the next cycle.
    a_push_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept && ((req.action == ACT_PUSH_FRONT) || (req.action == ACT_PUSH_BACK))
        |=> done_reg && (state_reg == ST_IDLE))
        else $error("push did not answer in one cycle");

    // The pop read cycle always ends with a result and a return to idle.
    a_pop_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |=> done_reg && (state_reg == ST_IDLE))
        else $error("pop did not finish after its read cycle");

    // A scan only runs over a non-empty deque and stays within the stored records.
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !is_empty && (scan_reg < count_reg))
        else $error("find scan outside the stored records");

endmodule
